[hw/rtl/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and codes of the first-fit allocator with compaction.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ADDR_W = 17;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DEFRAG = 2'd2;

  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_NULL    = 2'd1;
  localparam logic [1:0] OUT_ILLEGAL = 2'd2;

  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_SCAN     = 4'd2;
  localparam logic [3:0] OP_FOUND    = 4'd3;
  localparam logic [3:0] OP_TAIL     = 4'd4;
  localparam logic [3:0] OP_SHIFT_UP = 4'd5;
  localparam logic [3:0] OP_INSERT   = 4'd6;
  localparam logic [3:0] OP_FAIL     = 4'd7;
  localparam logic [3:0] OP_ILLEGAL  = 4'd8;
  localparam logic [3:0] OP_HSTEP    = 4'd9;
  localparam logic [3:0] OP_SHIFT_DN = 4'd10;
  localparam logic [3:0] OP_DEL_DONE = 4'd11;
  localparam logic [3:0] OP_DEFRAG   = 4'd12;

  typedef struct packed {
    logic [3:0] op;
  } dp_ctl_t;

  typedef struct packed {
    logic pre_fail;
    logic at_cnt;
    logic fit;
    logic tail_fit;
    logic h_zero;
    logic h_match;
    logic at_pos;
    logic at_last;
    logic out_busy;
  } dp_sts_t;

endpackage

[hw/rtl/ffa_req_if.sv]
// ----------------------------------------------------------------------------
// ffa_req_if
// Command channel: valid/ready with command, size and handle.
// ----------------------------------------------------------------------------
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] req_size;
  logic [15:0] req_handle;

  modport source (output valid, output cmd, output req_size, output req_handle,
                  input ready);
  modport sink (input valid, input cmd, input req_size, input req_handle,
                output ready);
endinterface

[hw/rtl/ffa_rsp_if.sv]
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Result channel: valid/ready with outcome and handle.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [15:0] handle_out;

  modport source (output valid, output outcome, output handle_out, input ready);
  modport sink (input valid, input outcome, input handle_out, output ready);
endinterface

[hw/rtl/ffa_datapath.sv]
// ----------------------------------------------------------------------------
// ffa_datapath
// Block table memory, scan registers, handle counter and result register.
// ----------------------------------------------------------------------------
module ffa_datapath #(
  parameter int MAX_BLOCKS  = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  ffa_pkg::dp_ctl_t ctl,
  output ffa_pkg::dp_sts_t sts,
  input  logic [15:0]      req_size,
  input  logic [15:0]      req_handle,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic [1:0]       outcome,
  output logic [15:0]      handle_out
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = AW + 1;
  localparam int HB = HANDLE_BITS;
  localparam int HW = (HB > 16) ? HB : 16;
  localparam int PW = ffa_pkg::ADDR_W;
  localparam int EW = HB + 2 * PW;

  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rdata;

  logic [15:0]   mem_size;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [PW-1:0] prev, prev_next;
  logic [15:0]   size_r;
  logic [15:0]   hreq;
  logic [HB-1:0] lh, lh_next;

  logic [HB-1:0] r_handle;
  logic [PW-1:0] r_start, r_end, len, new_end;
  logic [PW:0]   sum;
  logic [HB-1:0] lh_inc;
  logic [HW-1:0] lh_wide, r_handle_wide, hreq_wide;
  logic          we;
  logic [CW-1:0] waddr;
  logic [EW-1:0] wdata;

  assign r_handle = rdata[EW-1 -: HB];
  assign r_start  = rdata[2*PW-1 -: PW];
  assign r_end    = rdata[PW-1:0];
  assign sum      = {1'b0, prev} + (PW+1)'(size_r);
  assign len      = r_end - r_start;
  assign new_end  = prev + len;
  assign lh_inc   = lh + HB'(1);
  assign lh_wide       = HW'(lh_inc);
  assign r_handle_wide = HW'(r_handle);
  assign hreq_wide     = HW'(hreq);

  always_comb begin
    sts.pre_fail = (size_r > mem_size) || (cnt == CW'(MAX_BLOCKS)) || (lh == '1);
    sts.at_cnt   = (idx == cnt);
    sts.fit      = (sum <= {1'b0, r_start});
    sts.tail_fit = (sum <= ((PW+1)'(mem_size) + (PW+1)'(1)));
    sts.h_zero   = (hreq == 16'd0);
    sts.h_match  = (r_handle_wide == hreq_wide);
    sts.at_pos   = (idx == pos);
    sts.at_last  = ((idx + CW'(1)) == cnt);
    sts.out_busy = rsp_valid && !rsp_ready;
  end

  always_comb begin
    idx_next  = idx;
    pos_next  = pos;
    prev_next = prev;
    cnt_next  = cnt;
    lh_next   = lh;
    we        = 1'b0;
    waddr     = idx;
    wdata     = rdata;
    case (ctl.op)
      ffa_pkg::OP_LOAD: begin
        idx_next  = '0;
        prev_next = PW'(1);
      end
      ffa_pkg::OP_SCAN: begin
        prev_next = r_end;
        idx_next  = idx + CW'(1);
      end
      ffa_pkg::OP_FOUND: begin
        pos_next = idx;
        idx_next = cnt - CW'(1);
      end
      ffa_pkg::OP_TAIL: begin
        pos_next = cnt;
      end
      ffa_pkg::OP_SHIFT_UP: begin
        we       = 1'b1;
        waddr    = idx + CW'(1);
        idx_next = idx - CW'(1);
      end
      ffa_pkg::OP_INSERT: begin
        we       = 1'b1;
        waddr    = pos;
        wdata    = {lh_inc, prev, sum[PW-1:0]};
        cnt_next = cnt + CW'(1);
        lh_next  = lh_inc;
      end
      ffa_pkg::OP_HSTEP: begin
        idx_next = idx + CW'(1);
      end
      ffa_pkg::OP_SHIFT_DN: begin
        we       = 1'b1;
        waddr    = idx - CW'(1);
        idx_next = idx + CW'(1);
      end
      ffa_pkg::OP_DEL_DONE: begin
        cnt_next = cnt - CW'(1);
      end
      ffa_pkg::OP_DEFRAG: begin
        we        = 1'b1;
        wdata     = {r_handle, prev, new_end};
        prev_next = new_end;
        idx_next  = idx + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    rdata <= mem[idx_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    pos  <= pos_next;
    prev <= prev_next;
    if (ctl.op == ffa_pkg::OP_LOAD) begin
      size_r <= req_size;
      hreq   <= req_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size  <= 16'hFFFF;
      cnt       <= '0;
      lh        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mem_size <= cfg_wdata;
      end
      cnt <= cnt_next;
      lh  <= lh_next;
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (ctl.op == ffa_pkg::OP_INSERT || ctl.op == ffa_pkg::OP_FAIL ||
          ctl.op == ffa_pkg::OP_ILLEGAL) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      ffa_pkg::OP_INSERT: begin
        outcome    <= ffa_pkg::OUT_OK;
        handle_out <= lh_wide[15:0];
      end
      ffa_pkg::OP_FAIL: begin
        outcome    <= ffa_pkg::OUT_NULL;
        handle_out <= 16'd0;
      end
      ffa_pkg::OP_ILLEGAL: begin
        outcome    <= ffa_pkg::OUT_ILLEGAL;
        handle_out <= 16'd0;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate, delete and defragment walks over the table.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [1:0]       req_cmd,
  output logic             req_ready,
  input  ffa_pkg::dp_sts_t sts,
  output ffa_pkg::dp_ctl_t ctl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ASCAN  = 4'd1;
  localparam logic [3:0] S_ASHIFT = 4'd2;
  localparam logic [3:0] S_AINS   = 4'd3;
  localparam logic [3:0] S_AFAIL  = 4'd4;
  localparam logic [3:0] S_DSCAN  = 4'd5;
  localparam logic [3:0] S_DSHIFT = 4'd6;
  localparam logic [3:0] S_DDONE  = 4'd7;
  localparam logic [3:0] S_DILL   = 4'd8;
  localparam logic [3:0] S_FRUN   = 4'd9;

  logic [3:0] state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl.op     = ffa_pkg::OP_NOP;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.op = ffa_pkg::OP_LOAD;
          case (req_cmd)
            ffa_pkg::CMD_ALLOC:  state_next = S_ASCAN;
            ffa_pkg::CMD_DELETE: state_next = S_DSCAN;
            ffa_pkg::CMD_DEFRAG: state_next = S_FRUN;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_ASCAN: begin
        if (sts.pre_fail) begin
          state_next = S_AFAIL;
        end else if (sts.at_cnt) begin
          if (sts.tail_fit) begin
            ctl.op     = ffa_pkg::OP_TAIL;
            state_next = S_AINS;
          end else begin
            state_next = S_AFAIL;
          end
        end else if (sts.fit) begin
          ctl.op     = ffa_pkg::OP_FOUND;
          state_next = S_ASHIFT;
        end else begin
          ctl.op = ffa_pkg::OP_SCAN;
        end
      end
      S_ASHIFT: begin
        ctl.op = ffa_pkg::OP_SHIFT_UP;
        if (sts.at_pos) begin
          state_next = S_AINS;
        end
      end
      S_AINS: begin
        if (!sts.out_busy) begin
          ctl.op     = ffa_pkg::OP_INSERT;
          state_next = S_IDLE;
        end
      end
      S_AFAIL: begin
        if (!sts.out_busy) begin
          ctl.op     = ffa_pkg::OP_FAIL;
          state_next = S_IDLE;
        end
      end
      S_DSCAN: begin
        if (sts.h_zero || sts.at_cnt) begin
          state_next = S_DILL;
        end else if (sts.h_match) begin
          if (sts.at_last) begin
            state_next = S_DDONE;
          end else begin
            ctl.op     = ffa_pkg::OP_HSTEP;
            state_next = S_DSHIFT;
          end
        end else begin
          ctl.op = ffa_pkg::OP_HSTEP;
        end
      end
      S_DSHIFT: begin
        ctl.op = ffa_pkg::OP_SHIFT_DN;
        if (sts.at_last) begin
          state_next = S_DDONE;
        end
      end
      S_DDONE: begin
        ctl.op     = ffa_pkg::OP_DEL_DONE;
        state_next = S_IDLE;
      end
      S_DILL: begin
        if (!sts.out_busy) begin
          ctl.op     = ffa_pkg::OP_ILLEGAL;
          state_next = S_IDLE;
        end
      end
      S_FRUN: begin
        if (sts.at_cnt) begin
          state_next = S_IDLE;
        end else begin
          ctl.op = ffa_pkg::OP_DEFRAG;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/first_fit_allocator_with_compaction_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction_unit
// First-fit block allocator with delete and compaction over a block table.
// ----------------------------------------------------------------------------
// Commands enter on req (valid/ready): allocate, delete by handle, defragment.
// Results leave on rsp (valid/ready): one per allocate (handle or NULL) and
// one per illegal delete; a good delete, a defragment and command 3 give none.
// mem_size is written through cfg_we/cfg_wdata; the user must write it only
// while the unit is idle, as the unit itself does not enforce this.
// An allocate scans to its insert position and shifts later entries up, a
// delete scans to the handle and shifts later entries down, and a defragment
// walks all live blocks. The walk reads one table entry per cycle from the
// single-read-port memory; one item is in work at a time, ready between items.
// Reset clears the block count, the handle counter and the result valid flag
// and sets mem_size to 65535; the table needs no clearing pass.
// A stalled rsp holds its result; the unit finishes the next item's walk and
// then waits before posting its result.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_compaction_unit #(
  parameter int MAX_BLOCKS  = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ffa_req_if.sink     req,
  ffa_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  ffa_pkg::dp_ctl_t ctl;
  ffa_pkg::dp_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ffa_datapath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .req_size   (req.req_size),
    .req_handle (req.req_handle),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .outcome    (rsp.outcome),
    .handle_out (rsp.handle_out)
  );

endmodule

[hw/rtl/ffa_check.sv]
// ----------------------------------------------------------------------------
// ffa_check
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffa_check (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  outcome,
  input logic [15:0] handle_out
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(outcome) && $stable(handle_out))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (outcome == ffa_pkg::OUT_OK || outcome == ffa_pkg::OUT_NULL ||
                   outcome == ffa_pkg::OUT_ILLEGAL))
    else $error("unknown outcome");

  a_zero_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && outcome != ffa_pkg::OUT_OK |-> handle_out == 16'd0)
    else $error("handle on failed item");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result after reset");

endmodule

bind first_fit_allocator_with_compaction_unit ffa_check u_ffa_check (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .outcome    (rsp.outcome),
  .handle_out (rsp.handle_out)
);
